[src/step_dir_pulse_generator_core_defines.svh]
// Assertion macros shared by the checker.
`ifndef STEP_DIR_PULSE_GENERATOR_CORE_DEFINES_SVH
`define STEP_DIR_PULSE_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define SDPG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define SDPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/sdpg_pkg.sv]
`timescale 1ns / 1ps

package sdpg_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  localparam logic [31:0] POS_BIAS         = 32'h4000_0000;
  localparam logic [31:0] RAW_POS_RESET    = 32'hC000_0000;
  localparam logic [23:0] LATE_LIMIT_RESET = 24'd72000;

  typedef enum logic [2:0] {
    ACT_TICK      = 3'd0,
    ACT_QUEUE     = 3'd1,
    ACT_SET_DIR   = 3'd2,
    ACT_RESET_CLK = 3'd3,
    ACT_STOP      = 3'd4,
    ACT_READ_POS  = 3'd5
  } sdpg_action_e;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_ZERO_COUNT   = 3'd1,
    ERR_TOO_LATE     = 3'd2,
    ERR_RESET_ACTIVE = 3'd3,
    ERR_QUEUE_FULL   = 3'd4
  } sdpg_err_e;

  typedef enum logic [1:0] {
    CFG_PULSE_MIN   = 2'd0,
    CFG_SINGLE_EDGE = 2'd1,
    CFG_INVERT_STEP = 2'd2,
    CFG_LATE_LIMIT  = 2'd3
  } sdpg_cfg_idx_e;

  typedef struct packed {
    logic [15:0] pulse_min;
    logic        single_edge;
    logic        invert_step;
    logic [23:0] late_limit;
  } sdpg_cfg_t;

  // One queued move.
  typedef struct packed {
    logic [31:0] interval;
    logic [15:0] add;
    logic [15:0] count;
    logic        dir_chg;
  } sdpg_entry_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } sdpg_qctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } sdpg_qsts_t;

  // Post-transaction state that the result is built from.
  typedef struct packed {
    logic        step_level;
    logic        dir_level;
    logic [31:0] raw_pos;
    logic [16:0] edges;
    logic        single_edge;
    sdpg_err_e   err;
    logic        dropped;
  } sdpg_res_t;

  // Wrapping time compare: a lies before b.
  function automatic logic is_before(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] diff;
    diff = a - b;
    return diff[31];
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  // Steps taken so far, still biased; pending edges are taken back out.
  function automatic logic [31:0] cur_pos(input logic [31:0] raw,
                                          input logic [16:0] edges,
                                          input logic        single_edge);
    logic [31:0] pend;
    pend = single_edge ? {15'd0, edges} : {16'd0, edges[16:1]};
    return abs32(raw - pend);
  endfunction

endpackage

[src/sdpg_queue.sv]
`timescale 1ns / 1ps

module sdpg_queue #(
  parameter int unsigned QUEUE_DEPTH = sdpg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sdpg_pkg::sdpg_qctl_t  ctl_i,
  input  sdpg_pkg::sdpg_entry_t wr_entry_i,
  output sdpg_pkg::sdpg_qsts_t  sts_o,
  output sdpg_pkg::sdpg_entry_t head_entry_o
);

  localparam int unsigned HW = $clog2(QUEUE_DEPTH);
  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = FW + 1;

  logic [HW-1:0] head_q, head_d, slot;
  logic [FW-1:0] fill_q, fill_d;
  logic [SW-1:0] slot_sum;

  sdpg_pkg::sdpg_entry_t mem [QUEUE_DEPTH];
  sdpg_pkg::sdpg_entry_t rd_q;

  // Tail slot: head plus fill, wrapped once.
  always_comb begin
    slot_sum = SW'(head_q) + SW'(fill_q);
    if (slot_sum >= SW'(QUEUE_DEPTH)) begin
      slot_sum = slot_sum - SW'(QUEUE_DEPTH);
    end
    slot = slot_sum[HW-1:0];
  end

  always_comb begin
    priority if (ctl_i.flush) begin
      head_d = '0;
      fill_d = '0;
    end else begin
      head_d = head_q;
      if (ctl_i.pop) begin
        head_d = (head_q == HW'(QUEUE_DEPTH - 1)) ? '0 : head_q + HW'(1);
      end
      fill_d = fill_q + FW'(ctl_i.push) - FW'(ctl_i.pop);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
    end
  end

  // Keep the read port on the next head; forward a same-cycle write to it.
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem[slot] <= wr_entry_i;
    end
    if (ctl_i.push && (slot == head_d)) begin
      rd_q <= wr_entry_i;
    end else begin
      rd_q <= mem[head_d];
    end
  end

  assign sts_o.empty  = (fill_q == '0);
  assign sts_o.full   = (fill_q >= FW'(QUEUE_DEPTH));
  // An empty queue hands the incoming move straight through.
  assign head_entry_o = sts_o.empty ? wr_entry_i : rd_q;

endmodule

[src/sdpg_sched.sv]
`timescale 1ns / 1ps

module sdpg_sched (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [2:0]            action_i,
  input  logic [31:0]           move_interval_i,
  input  logic [15:0]           move_count_i,
  input  logic signed [15:0]    move_add_i,
  input  logic                  next_dir_i,
  input  logic [31:0]           clock_value_i,
  input  sdpg_pkg::sdpg_cfg_t   cfg_i,
  input  sdpg_pkg::sdpg_qsts_t  qsts_i,
  input  sdpg_pkg::sdpg_entry_t head_entry_i,
  output sdpg_pkg::sdpg_qctl_t  qctl_o,
  output sdpg_pkg::sdpg_entry_t wr_entry_o,
  output sdpg_pkg::sdpg_res_t   res_o
);

  sdpg_pkg::sdpg_action_e act;
  sdpg_pkg::sdpg_err_e    err;

  logic [31:0] cur_interval_q, cur_interval_d;
  logic [15:0] cur_inc_q, cur_inc_d;
  logic [16:0] edges_q, edges_d;
  logic [31:0] nst_q, nst_d;
  logic [31:0] wake_q, wake_d;
  logic [31:0] now_q, now_d;
  logic [31:0] raw_q, raw_d;
  logic        dir_last_q, dir_last_d;
  logic        dir_next_q, dir_next_d;
  logic        step_pin_q, step_pin_d;
  logic        dir_pin_q, dir_pin_d;
  logic        halted_q, halted_d;

  logic [31:0] now_inc, tick_min, tick_min2, nst_step, nst_load, late_diff, mnl;
  logic [31:0] stop_p, hold_min;
  logic [16:0] edges_dec;
  logic        dir_mark, do_load, was_active, stop_req, stop, push, pop, drop;

  assign act = sdpg_pkg::sdpg_action_e'(action_i);

  assign now_inc   = now_q + 32'd1;
  assign tick_min  = now_inc + {16'd0, cfg_i.pulse_min};
  assign tick_min2 = now_inc + {15'd0, cfg_i.pulse_min, 1'b0};
  assign nst_step  = nst_q + cur_interval_q;
  assign nst_load  = nst_q + head_entry_i.interval;
  assign edges_dec = edges_q - 17'd1;
  assign dir_mark  = dir_last_q ^ dir_next_q;
  assign late_diff = mnl - nst_load;
  // Direction hold-off after a step edge; single-edge mode doubles the minimum pulse.
  assign hold_min  = cfg_i.single_edge ? tick_min2 : tick_min;

  assign wr_entry_o.interval = move_interval_i;
  assign wr_entry_o.add      = move_add_i;
  assign wr_entry_o.count    = move_count_i;
  assign wr_entry_o.dir_chg  = dir_mark;

  always_comb begin
    cur_interval_d = cur_interval_q;
    cur_inc_d      = cur_inc_q;
    edges_d        = edges_q;
    nst_d          = nst_q;
    wake_d         = wake_q;
    now_d          = now_q;
    raw_d          = raw_q;
    dir_last_d     = dir_last_q;
    dir_next_d     = dir_next_q;
    step_pin_d     = step_pin_q;
    dir_pin_d      = dir_pin_q;
    halted_d       = halted_q;
    err            = sdpg_pkg::ERR_NONE;
    drop           = 1'b0;
    push           = 1'b0;
    pop            = 1'b0;
    do_load        = 1'b0;
    was_active     = 1'b0;
    stop_req       = 1'b0;
    mnl            = wake_q;

    unique case (act)
      sdpg_pkg::ACT_TICK: begin
        now_d = now_inc;
        if ((edges_q != '0) && !sdpg_pkg::is_before(now_inc, wake_q)) begin
          step_pin_d = ~step_pin_q;
          if (edges_dec[0] && !cfg_i.single_edge) begin
            // Unstep edge next, after the minimum pulse.
            edges_d = edges_dec;
            wake_d  = tick_min;
          end else if (edges_dec != '0) begin
            nst_d          = nst_step;
            cur_interval_d = cur_interval_q + {{16{cur_inc_q[15]}}, cur_inc_q};
            edges_d        = edges_dec;
            wake_d         = sdpg_pkg::is_before(nst_step, tick_min) ? tick_min : nst_step;
          end else begin
            // Move finished: pull the next one.
            wake_d     = tick_min;
            mnl        = tick_min;
            do_load    = 1'b1;
            was_active = 1'b1;
          end
        end
      end
      sdpg_pkg::ACT_QUEUE: begin
        priority if (move_count_i == '0) begin
          err = sdpg_pkg::ERR_ZERO_COUNT;
        end else if (halted_q) begin
          drop = 1'b1;
        end else if (qsts_i.full) begin
          err = sdpg_pkg::ERR_QUEUE_FULL;
        end else begin
          push       = 1'b1;
          dir_last_d = dir_next_q;
          do_load    = (edges_q == '0);
        end
      end
      sdpg_pkg::ACT_SET_DIR: begin
        dir_next_d = next_dir_i;
      end
      sdpg_pkg::ACT_RESET_CLK: begin
        if (edges_q != '0) begin
          err = sdpg_pkg::ERR_RESET_ACTIVE;
        end else begin
          nst_d    = clock_value_i;
          wake_d   = clock_value_i;
          halted_d = 1'b0;
        end
      end
      sdpg_pkg::ACT_STOP: begin
        stop_req = 1'b1;
      end
      default: begin
      end
    endcase

    if (do_load) begin
      if (!push && qsts_i.empty) begin
        edges_d = '0;
      end else begin
        pop            = 1'b1;
        raw_d          = (head_entry_i.dir_chg ? (32'd0 - raw_q) : raw_q)
                         + {16'd0, head_entry_i.count};
        cur_inc_d      = head_entry_i.add;
        cur_interval_d = head_entry_i.interval
                         + {{16{head_entry_i.add[15]}}, head_entry_i.add};
        nst_d          = nst_load;
        wake_d         = nst_load;
        edges_d        = cfg_i.single_edge ? {1'b0, head_entry_i.count}
                                           : {head_entry_i.count, 1'b0};
        if (was_active && sdpg_pkg::is_before(nst_load, mnl)) begin
          if (late_diff > {8'd0, cfg_i.late_limit}) begin
            err = sdpg_pkg::ERR_TOO_LATE;
          end else begin
            wake_d = mnl;
          end
        end
        if ((err != sdpg_pkg::ERR_TOO_LATE) && head_entry_i.dir_chg) begin
          dir_pin_d = ~dir_pin_q;
          if (was_active && sdpg_pkg::is_before(wake_d, hold_min)) begin
            wake_d = hold_min;
          end
        end
      end
    end

    stop = stop_req || (err == sdpg_pkg::ERR_ZERO_COUNT) ||
           (err == sdpg_pkg::ERR_TOO_LATE) || (err == sdpg_pkg::ERR_RESET_ACTIVE);

    // A late step leaves edges matching the fresh count, so the position is raw.
    if (err == sdpg_pkg::ERR_TOO_LATE) begin
      stop_p = sdpg_pkg::abs32(head_entry_i.dir_chg ? (32'd0 - raw_q) : raw_q);
    end else begin
      stop_p = sdpg_pkg::cur_pos(raw_q, edges_q, cfg_i.single_edge);
    end

    if (stop) begin
      raw_d      = 32'd0 - stop_p;
      nst_d      = '0;
      wake_d     = '0;
      edges_d    = '0;
      dir_last_d = 1'b0;
      dir_next_d = 1'b0;
      halted_d   = 1'b1;
      dir_pin_d  = 1'b0;
      if (!cfg_i.single_edge) begin
        step_pin_d = cfg_i.invert_step;
      end
    end
  end

  assign qctl_o.push  = accept_i & push;
  assign qctl_o.pop   = accept_i & pop & ~stop;
  assign qctl_o.flush = accept_i & stop;

  assign res_o.step_level  = step_pin_d;
  assign res_o.dir_level   = dir_pin_d;
  assign res_o.raw_pos     = raw_d;
  assign res_o.edges       = edges_d;
  assign res_o.single_edge = cfg_i.single_edge;
  assign res_o.err         = err;
  assign res_o.dropped     = drop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_interval_q <= '0;
      cur_inc_q      <= '0;
      edges_q        <= '0;
      nst_q          <= '0;
      wake_q         <= '0;
      now_q          <= '0;
      raw_q          <= sdpg_pkg::RAW_POS_RESET;
      dir_last_q     <= 1'b0;
      dir_next_q     <= 1'b0;
      step_pin_q     <= 1'b0;
      dir_pin_q      <= 1'b0;
      halted_q       <= 1'b0;
    end else if (accept_i) begin
      cur_interval_q <= cur_interval_d;
      cur_inc_q      <= cur_inc_d;
      edges_q        <= edges_d;
      nst_q          <= nst_d;
      wake_q         <= wake_d;
      now_q          <= now_d;
      raw_q          <= raw_d;
      dir_last_q     <= dir_last_d;
      dir_next_q     <= dir_next_d;
      step_pin_q     <= step_pin_d;
      dir_pin_q      <= dir_pin_d;
      halted_q       <= halted_d;
    end
  end

endmodule

[src/sdpg_outreg.sv]
`timescale 1ns / 1ps

module sdpg_outreg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  sdpg_pkg::sdpg_res_t res_i,
  input  logic                out_ready_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  output logic                step_level_o,
  output logic                dir_level_o,
  output logic signed [31:0]  position_o,
  output logic                busy_res_o,
  output logic [2:0]          error_code_o,
  output logic                dropped_o
);

  logic                valid_q, valid_d;
  sdpg_pkg::sdpg_res_t res_q;

  assign in_ready_o = ~valid_q | out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (accept_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign step_level_o = res_q.step_level;
  assign dir_level_o  = res_q.dir_level;
  // Remove pending edges and the bias from the captured raw position.
  assign position_o   = $signed(sdpg_pkg::cur_pos(res_q.raw_pos, res_q.edges,
                                                  res_q.single_edge) - sdpg_pkg::POS_BIAS);
  assign busy_res_o   = (res_q.edges != '0);
  assign error_code_o = res_q.err;
  assign dropped_o    = res_q.dropped;

endmodule

[src/step_dir_pulse_generator_core.sv]
// Step/direction pulse generator: one transaction per clock unless a waiting result stalls
// the input, result registered for the next cycle. The rate rests on the joint update of
// tick, wake and step state and on the move queue's read port, always on the next head.
// Reset (rst_ni, async, active low): control state and the valid flag clear, the position
// is biased, config takes its reset values; the queue memory needs no clearing pass.
`timescale 1ns / 1ps

module step_dir_pulse_generator_core #(
  parameter int unsigned QUEUE_DEPTH = sdpg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input transaction
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         action_i,
  input  logic [31:0]        move_interval_i,
  input  logic [15:0]        move_count_i,
  input  logic signed [15:0] move_add_i,
  input  logic               next_dir_i,
  input  logic [31:0]        clock_value_i,
  // result transaction
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               step_level_o,
  output logic               dir_level_o,
  output logic signed [31:0] position_o,
  output logic               busy_res_o,
  output logic [2:0]         error_code_o,
  output logic               dropped_o,
  // configuration writes
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i
);

  sdpg_pkg::sdpg_cfg_t   cfg_q;
  sdpg_pkg::sdpg_qctl_t  qctl;
  sdpg_pkg::sdpg_qsts_t  qsts;
  sdpg_pkg::sdpg_entry_t wr_entry, head_entry;
  sdpg_pkg::sdpg_res_t   res;
  sdpg_pkg::sdpg_cfg_idx_e cfg_idx;
  logic                  accept;

  // Take a new transaction whenever the output register is free or draining.
  assign accept  = in_valid_i & in_ready_o;
  assign cfg_idx = sdpg_pkg::sdpg_cfg_idx_e'(cfg_index_i);

  // Configuration registers; writes take effect at once and never touch the pins.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_min   <= '0;
      cfg_q.single_edge <= 1'b0;
      cfg_q.invert_step <= 1'b0;
      cfg_q.late_limit  <= sdpg_pkg::LATE_LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx)
        sdpg_pkg::CFG_PULSE_MIN:   cfg_q.pulse_min   <= cfg_data_i[15:0];
        sdpg_pkg::CFG_SINGLE_EDGE: cfg_q.single_edge <= cfg_data_i[0];
        sdpg_pkg::CFG_INVERT_STEP: cfg_q.invert_step <= cfg_data_i[0];
        sdpg_pkg::CFG_LATE_LIMIT:  cfg_q.late_limit  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Move queue: one memory, registered read of the head with write forwarding.
  sdpg_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (qctl),
    .wr_entry_i   (wr_entry),
    .sts_o        (qsts),
    .head_entry_o (head_entry)
  );

  // Tick, step, load and stop logic; updates all scalar state per transaction.
  sdpg_sched u_sched (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .action_i        (action_i),
    .move_interval_i (move_interval_i),
    .move_count_i    (move_count_i),
    .move_add_i      (move_add_i),
    .next_dir_i      (next_dir_i),
    .clock_value_i   (clock_value_i),
    .cfg_i           (cfg_q),
    .qsts_i          (qsts),
    .head_entry_i    (head_entry),
    .qctl_o          (qctl),
    .wr_entry_o      (wr_entry),
    .res_o           (res)
  );

  // Output register decouples the result side from the input side.
  sdpg_outreg u_outreg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .res_i        (res),
    .out_ready_i  (out_ready_i),
    .in_ready_o   (in_ready_o),
    .out_valid_o  (out_valid_o),
    .step_level_o (step_level_o),
    .dir_level_o  (dir_level_o),
    .position_o   (position_o),
    .busy_res_o   (busy_res_o),
    .error_code_o (error_code_o),
    .dropped_o    (dropped_o)
  );

endmodule

[src/sdpg_checker.sv]
`timescale 1ns / 1ps
`include "step_dir_pulse_generator_core_defines.svh"

module sdpg_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [2:0]         action_i,
  input logic [31:0]        move_interval_i,
  input logic [15:0]        move_count_i,
  input logic signed [15:0] move_add_i,
  input logic               next_dir_i,
  input logic [31:0]        clock_value_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               step_level_o,
  input logic               dir_level_o,
  input logic signed [31:0] position_o,
  input logic               busy_res_o,
  input logic [2:0]         error_code_o,
  input logic               dropped_o,
  input logic               cfg_we_i,
  input logic [1:0]         cfg_index_i,
  input logic [23:0]        cfg_data_i
);

  // A stalled result holds.
  `SDPG_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(position_o) && $stable(error_code_o), "result changed while stalled")

  // Every accepted transaction yields a result in the next cycle.
  `SDPG_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, in_valid_i && in_ready_o,
    out_valid_o, "accepted transaction gave no result")

  // Input side only stalls behind a waiting result.
  `SDPG_ASSERT_NOW(a_ready_when_free, clk_i, rst_ni, !in_ready_o,
    out_valid_o, "input stalled with empty output register")

  // A fatal error stops the generator and parks the direction pin.
  `SDPG_ASSERT_NOW(a_fatal_stops, clk_i, rst_ni,
    out_valid_o && (error_code_o == 3'd1 || error_code_o == 3'd2 || error_code_o == 3'd3),
    !busy_res_o && !dir_level_o, "fatal error left generator running")

  // A dropped move carries no error.
  `SDPG_ASSERT_NOW(a_drop_no_err, clk_i, rst_ni, out_valid_o && dropped_o,
    error_code_o == 3'd0, "dropped move reported an error")

endmodule

bind step_dir_pulse_generator_core sdpg_checker u_sdpg_checker (.*);
